>>> sv/tld_pkg.sv
// Shared types and constants of the timestamp lock detector.
`timescale 1ns / 1ps
package tld_pkg;

  localparam int TS_W        = 32;
  localparam int SAMP_W      = 64;
  localparam int CNT_W       = 8;
  localparam int IN_TDATA_W  = 256;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 160;
  localparam int OUT_TUSER_W = 6;

  localparam logic [CNT_W-1:0] LOCK_CNT_RST = 8'd8;

  typedef enum logic [1:0] {
    OP_MODE   = 2'd0,
    OP_HALT   = 2'd1,
    OP_STREAM = 2'd2,
    OP_AUDIO  = 2'd3
  } op_t;

  // Packed from the top bit down, so the last member sits in the lowest bits.
  typedef struct packed {
    logic has_timestamp;
    logic has_puller;
    op_t  op;
  } in_user_t;

  typedef struct packed {
    logic [TS_W-1:0]   sample_rate;
    logic [TS_W-1:0]   jiffies_per_sample;
    logic [TS_W-1:0]   max_deviation;
    logic [SAMP_W-1:0] sample_start;
    logic [TS_W-1:0]   duration_jiffies;
    logic [TS_W-1:0]   rx_ts;
    logic [TS_W-1:0]   network_ts;
  } in_data_t;

  typedef struct packed {
    logic rate_notify;
    logic puller_stop;
    logic puller_start;
    logic drift_valid;
    logic new_stream;
    logic forward;
  } out_user_t;

  typedef struct packed {
    logic [TS_W-1:0]        notify_rate;
    logic [TS_W-1:0]        drift_network_ts;
    logic signed [TS_W-1:0] drift;
    logic [SAMP_W-1:0]      new_sample_start;
  } out_data_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;
    logic commit;
    logic div_load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
  } status_t;

endpackage

>>> sv/tld_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tld_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tld_pkg::SAMP_W-1:0]    dividend,
  input  logic [tld_pkg::TS_W-1:0]      divisor,
  output logic [tld_pkg::SAMP_W-1:0]    quotient,
  output logic                          done
);

  localparam int STEP_W = $clog2(tld_pkg::SAMP_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(tld_pkg::SAMP_W - 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [tld_pkg::SAMP_W-1:0]  quo_r, quo_nxt;
  logic [tld_pkg::TS_W-1:0]    rem_r, rem_nxt;
  logic [tld_pkg::TS_W-1:0]    dsor_r, dsor_nxt;
  logic [tld_pkg::TS_W:0]      trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsor_nxt = dsor_r;
    trial    = {rem_r, quo_r[tld_pkg::SAMP_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsor_nxt = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsor_r}) begin
        rem_nxt = tld_pkg::TS_W'(trial - {1'b0, dsor_r});
        quo_nxt = {quo_r[tld_pkg::SAMP_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[tld_pkg::TS_W-1:0];
        quo_nxt = {quo_r[tld_pkg::SAMP_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsor_r <= dsor_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

>>> sv/tld_datapath.sv
// Datapath: lock state, per-message evaluation, divider and result register.
`timescale 1ns / 1ps
module tld_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [tld_pkg::CNT_W-1:0]      cfg_wr_data,
  input  tld_pkg::in_user_t              in_user,
  input  tld_pkg::in_data_t              in_data,
  input  tld_pkg::cmd_t                  cmd,
  output tld_pkg::status_t               status,
  output tld_pkg::out_user_t             out_user,
  output tld_pkg::out_data_t             out_data
);

  localparam int TW = tld_pkg::TS_W;
  localparam int SW = tld_pkg::SAMP_W;
  localparam int CW = tld_pkg::CNT_W;

  tld_pkg::in_user_t  in_u_r;
  tld_pkg::in_data_t  in_d_r;
  tld_pkg::out_user_t out_u_r;
  tld_pkg::out_data_t out_d_r;
  tld_pkg::out_user_t res_u;
  tld_pkg::out_data_t res_d;

  logic [CW-1:0] lock_cnt_r;

  logic          puller_present_r, puller_present_nxt;
  logic          check_pending_r, check_pending_nxt;
  logic          is_ts_r, is_ts_nxt;
  logic          locked_r, locked_nxt;
  logic          recompute_r, recompute_nxt;
  logic [CW-1:0] msgs_left_r, msgs_left_nxt;
  logic [TW-1:0] ref_delta_r, ref_delta_nxt;
  logic [SW-1:0] disc_total_r, disc_total_nxt;
  logic          have_stream_r, have_stream_nxt;
  logic [SW-1:0] first_sample_r, first_sample_nxt;
  logic [TW-1:0] dev_limit_r, dev_limit_nxt;
  logic [TW-1:0] jps_r, jps_nxt;
  logic [TW-1:0] rate_r, rate_nxt;

  logic          need_div;
  logic [TW-1:0] delta;
  logic [TW-1:0] diff;
  logic [TW-1:0] mag;
  logic [CW-1:0] msgs_dec;
  logic [SW-1:0] disc_sum;
  logic [SW-1:0] quotient;
  logic [SW-1:0] samples;
  logic          div_done;

  assign delta    = in_d_r.rx_ts - in_d_r.network_ts;
  assign diff     = ref_delta_r - delta;
  assign mag      = diff[TW-1] ? (TW'(0) - diff) : diff;
  assign msgs_dec = msgs_left_r - 1'b1;
  assign disc_sum = disc_total_r + {{(SW-TW){1'b0}}, in_d_r.duration_jiffies};

  always_comb begin
    res_u              = '0;
    res_d              = '0;
    res_u.forward      = 1'b1;
    need_div           = 1'b0;
    puller_present_nxt = puller_present_r;
    check_pending_nxt  = check_pending_r;
    is_ts_nxt          = is_ts_r;
    locked_nxt         = locked_r;
    recompute_nxt      = recompute_r;
    msgs_left_nxt      = msgs_left_r;
    ref_delta_nxt      = ref_delta_r;
    disc_total_nxt     = disc_total_r;
    have_stream_nxt    = have_stream_r;
    first_sample_nxt   = first_sample_r;
    dev_limit_nxt      = dev_limit_r;
    jps_nxt            = jps_r;
    rate_nxt           = rate_r;
    unique case (in_u_r.op)
      tld_pkg::OP_MODE: begin
        res_u.puller_stop  = is_ts_r && (puller_present_r || in_u_r.has_puller);
        puller_present_nxt = in_u_r.has_puller;
        check_pending_nxt  = in_u_r.has_puller;
        is_ts_nxt          = 1'b0;
        locked_nxt         = 1'b0;
        recompute_nxt      = 1'b1;
        msgs_left_nxt      = '0;
        ref_delta_nxt      = '0;
        disc_total_nxt     = '0;
      end
      tld_pkg::OP_HALT: begin
        if (is_ts_r) begin
          locked_nxt    = 1'b0;
          msgs_left_nxt = lock_cnt_r;
          ref_delta_nxt = '0;
          recompute_nxt = 1'b1;
        end
      end
      tld_pkg::OP_STREAM: begin
        have_stream_nxt  = 1'b1;
        first_sample_nxt = in_d_r.sample_start;
        dev_limit_nxt    = in_d_r.max_deviation;
        jps_nxt          = in_d_r.jiffies_per_sample;
        rate_nxt         = in_d_r.sample_rate;
        if (is_ts_r && puller_present_r) begin
          res_u.rate_notify = 1'b1;
          res_d.notify_rate = in_d_r.sample_rate;
        end
      end
      tld_pkg::OP_AUDIO: begin
        // The first audio block after a mode change with a puller decides timestamp mode.
        if (check_pending_r) begin
          is_ts_nxt = in_u_r.has_timestamp;
          if (in_u_r.has_timestamp && puller_present_r) begin
            res_u.puller_start = 1'b1;
            res_u.rate_notify  = 1'b1;
            res_d.notify_rate  = rate_r;
          end
          locked_nxt        = !in_u_r.has_timestamp;
          recompute_nxt     = in_u_r.has_timestamp;
          check_pending_nxt = 1'b0;
        end
        if (is_ts_nxt) begin
          if (!locked_nxt) begin
            res_u.forward  = 1'b0;
            disc_total_nxt = disc_sum;
            if (in_u_r.has_timestamp) begin
              if (recompute_nxt) begin
                ref_delta_nxt = delta;
                msgs_left_nxt = lock_cnt_r - 1'b1;
                recompute_nxt = 1'b0;
              end else if (mag > dev_limit_r) begin
                msgs_left_nxt = lock_cnt_r;
                recompute_nxt = 1'b1;
                ref_delta_nxt = '0;
              end else begin
                msgs_left_nxt = msgs_dec;
                if (msgs_dec == '0) begin
                  locked_nxt       = 1'b1;
                  need_div         = have_stream_r;
                  res_u.new_stream = have_stream_r;
                  disc_total_nxt   = '0;
                  have_stream_nxt  = 1'b0;
                end
              end
            end
          end else if (in_u_r.has_timestamp && puller_present_r) begin
            res_u.drift_valid      = 1'b1;
            res_d.drift            = diff;
            res_d.drift_network_ts = in_d_r.network_ts;
          end
        end
      end
      default: begin
        res_u = '0;
      end
    endcase
  end

  tld_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.commit && need_div),
    .dividend (disc_sum),
    .divisor  (jps_r),
    .quotient (quotient),
    .done     (div_done)
  );

  // A zero divisor counts no discarded samples.
  assign samples = (jps_r == '0) ? '0 : quotient;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_cnt_r       <= tld_pkg::LOCK_CNT_RST;
      puller_present_r <= 1'b0;
      check_pending_r  <= 1'b0;
      is_ts_r          <= 1'b0;
      locked_r         <= 1'b0;
      recompute_r      <= 1'b0;
      msgs_left_r      <= '0;
      ref_delta_r      <= '0;
      disc_total_r     <= '0;
      have_stream_r    <= 1'b0;
      first_sample_r   <= '0;
      dev_limit_r      <= '0;
      jps_r            <= TW'(1);
      rate_r           <= '0;
    end else begin
      if (cfg_wr_en) begin
        lock_cnt_r <= cfg_wr_data;
      end
      if (cmd.commit) begin
        puller_present_r <= puller_present_nxt;
        check_pending_r  <= check_pending_nxt;
        is_ts_r          <= is_ts_nxt;
        locked_r         <= locked_nxt;
        recompute_r      <= recompute_nxt;
        msgs_left_r      <= msgs_left_nxt;
        ref_delta_r      <= ref_delta_nxt;
        disc_total_r     <= disc_total_nxt;
        have_stream_r    <= have_stream_nxt;
        first_sample_r   <= first_sample_nxt;
        dev_limit_r      <= dev_limit_nxt;
        jps_r            <= jps_nxt;
        rate_r           <= rate_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_u_r <= in_user;
      in_d_r <= in_data;
    end
    if (cmd.commit) begin
      out_u_r <= res_u;
      out_d_r <= res_d;
    end
    if (cmd.div_load_out) begin
      out_d_r.new_sample_start <= first_sample_r + samples;
    end
  end

  assign status.need_div = need_div;
  assign status.div_done = div_done;
  assign out_user        = out_u_r;
  assign out_data        = out_d_r;

endmodule

>>> sv/tld_ctrl.sv
// Controller: sequences accept, evaluation, division and result hand-off.
`timescale 1ns / 1ps
module tld_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tld_pkg::status_t  status,
  output tld_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          if (status.need_div) begin
            state_nxt = ST_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.div_load_out = 1'b1;
          out_valid_nxt    = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> sv/timestamp_lock_detector_top.sv
// Top level of the timestamp lock detector: stream ports, controller and datapath.
`timescale 1ns / 1ps
// The block takes one message event per input transfer and returns exactly one
// result transfer for it. Most events are captured into an input register on
// acceptance, then evaluated and the lock state updated once the output register is free.
// The event that completes a lock while a stream start is held also runs the
// count of discarded jiffies through a one-bit-per-cycle 64-bit divider before
// its new sample start goes into the result. The result sits in
// an output register, and the next event is accepted while it waits there; a
// new result is only written once the previous one has been transferred.
// Configuration of the lock count is a plain write and is meant for idle time.
module timestamp_lock_detector_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration: lock_msg_count.
  input  logic                                cfg_wr_en,
  input  logic [tld_pkg::CNT_W-1:0]           cfg_wr_data,
  // Input channel.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: network_ts, rx_ts, duration_jiffies, sample_start,
  // max_deviation, jiffies_per_sample, sample_rate.
  input  logic [tld_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Fields from bit 0 up: op (2 bits), has_puller, has_timestamp.
  input  logic [tld_pkg::IN_TUSER_W-1:0]      in_tuser,
  // Result channel.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: new_sample_start, drift, drift_network_ts,
  // notify_rate.
  output logic [tld_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // Fields from bit 0 up: forward, new_stream, drift_valid, puller_start,
  // puller_stop, rate_notify.
  output logic [tld_pkg::OUT_TUSER_W-1:0]     out_tuser
);

  tld_pkg::cmd_t      cmd;
  tld_pkg::status_t   status;
  tld_pkg::out_user_t out_user;
  tld_pkg::out_data_t out_data;

  // The controller owns the handshakes and tells the datapath when to capture
  // an event, when to commit its state update and when the divided sample
  // count is ready to go into the result.
  tld_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  tld_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_user     (tld_pkg::in_user_t'(in_tuser)),
    .in_data     (tld_pkg::in_data_t'(in_tdata)),
    .cmd         (cmd),
    .status      (status),
    .out_user    (out_user),
    .out_data    (out_data)
  );

  assign out_tdata = out_data;
  assign out_tuser = out_user;

  // Events are handled one at a time: a transfer is never followed directly
  // by another.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an event is still being evaluated");

  // A replacement stream start only comes with a dropped audio block.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_user.new_stream) |-> !out_user.forward)
    else $error("replacement stream start on a forwarded block");

  // Drift is only reported for locked blocks, which always pass downstream.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_user.drift_valid) |-> out_user.forward)
    else $error("drift report on a dropped block");

  // The divider result arrives only while the controller waits for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> !in_tready)
    else $error("divider finished while the controller was idle");

endmodule

>>> dv/tld_event_checker.sv
// Watches the lock detector's channels, predicts every result and compares it.
`timescale 1ns / 1ps
module tld_event_checker
  import tld_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CNT_W-1:0]       cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int                     failures,
  output int                     outstanding,
  output int                     results_seen,
  output int                     new_streams_seen,
  output int                     drifts_seen
);

  typedef struct packed {
    out_user_t u;
    out_data_t d;
  } result_t;

  result_t expected_q[$];

  // Lock count register and the tracked state of the detector.
  logic [CNT_W-1:0]  lock_target;
  logic              mode_has_puller;
  logic              await_first_audio;
  logic              stream_ts;
  logic              is_locked;
  logic              need_new_ref;
  logic [CNT_W-1:0]  consistent_left;
  logic [TS_W-1:0]   held_delta;
  logic [SAMP_W-1:0] dropped_jiffies;
  logic              stream_held;
  logic [SAMP_W-1:0] held_first_sample;
  logic [TS_W-1:0]   held_max_dev;
  logic [TS_W-1:0]   held_jps;
  logic [TS_W-1:0]   held_rate;

  task automatic predict_outcome(input in_user_t u, input in_data_t d,
                                 output out_user_t eu, output out_data_t ed);
    logic [TS_W-1:0]   delta;
    logic [TS_W-1:0]   diff;
    logic [TS_W-1:0]   mag;
    logic [SAMP_W-1:0] samples;
    eu = '0;
    ed = '0;
    eu.forward = 1'b1;
    delta = d.rx_ts - d.network_ts;
    case (u.op)
      OP_MODE: begin
        if (stream_ts && (mode_has_puller || u.has_puller)) eu.puller_stop = 1'b1;
        mode_has_puller   = u.has_puller;
        await_first_audio = u.has_puller;
        stream_ts         = 1'b0;
        is_locked         = 1'b0;
        need_new_ref      = 1'b1;
        consistent_left   = '0;
        held_delta        = '0;
        dropped_jiffies   = '0;
      end
      OP_HALT: begin
        if (stream_ts) begin
          is_locked       = 1'b0;
          consistent_left = lock_target;
          held_delta      = '0;
          need_new_ref    = 1'b1;
        end
      end
      OP_STREAM: begin
        stream_held       = 1'b1;
        held_first_sample = d.sample_start;
        held_max_dev      = d.max_deviation;
        held_jps          = d.jiffies_per_sample;
        held_rate         = d.sample_rate;
        if (stream_ts && mode_has_puller) begin
          eu.rate_notify = 1'b1;
          ed.notify_rate = held_rate;
        end
      end
      OP_AUDIO: begin
        // The first audio block after a mode change with a puller decides the stream kind.
        if (await_first_audio) begin
          stream_ts = u.has_timestamp;
          if (stream_ts && mode_has_puller) begin
            eu.puller_start = 1'b1;
            eu.rate_notify  = 1'b1;
            ed.notify_rate  = held_rate;
          end
          is_locked         = !stream_ts;
          need_new_ref      = stream_ts;
          await_first_audio = 1'b0;
        end
        if (stream_ts && !is_locked) begin
          eu.forward = 1'b0;
          dropped_jiffies = dropped_jiffies + SAMP_W'(d.duration_jiffies);
          if (u.has_timestamp) begin
            if (need_new_ref) begin
              held_delta      = delta;
              consistent_left = lock_target - 1'b1;
              need_new_ref    = 1'b0;
            end else begin
              diff = held_delta - delta;
              mag  = diff[TS_W-1] ? (32'd0 - diff) : diff;
              if (mag > held_max_dev) begin
                consistent_left = lock_target;
                need_new_ref    = 1'b1;
                held_delta      = '0;
              end else begin
                consistent_left = consistent_left - 1'b1;
                if (consistent_left == '0) begin
                  is_locked = 1'b1;
                  if (stream_held) begin
                    samples = (held_jps == '0) ? '0 : dropped_jiffies / held_jps;
                    eu.new_stream       = 1'b1;
                    ed.new_sample_start = held_first_sample + samples;
                  end
                  dropped_jiffies = '0;
                  stream_held     = 1'b0;
                end
              end
            end
          end
        end else if (stream_ts && u.has_timestamp && mode_has_puller) begin
          eu.drift_valid      = 1'b1;
          ed.drift            = held_delta - delta;
          ed.drift_network_ts = d.network_ts;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("Result %0d, %s: expected %0h, got %0h", results_seen, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      lock_target       = LOCK_CNT_RST;
      mode_has_puller   = 1'b0;
      await_first_audio = 1'b0;
      stream_ts         = 1'b0;
      is_locked         = 1'b0;
      need_new_ref      = 1'b0;
      consistent_left   = '0;
      held_delta        = '0;
      dropped_jiffies   = '0;
      stream_held       = 1'b0;
      held_first_sample = '0;
      held_max_dev      = '0;
      held_jps          = 32'd1;
      held_rate         = '0;
      expected_q.delete();
      outstanding       = 0;
    end else begin
      if (cfg_wr_en) lock_target = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        predict_outcome(in_user_t'(in_tuser), in_data_t'(in_tdata), want.u, want.d);
        expected_q.push_back(want);
        if (want.u.new_stream) new_streams_seen++;
        if (want.u.drift_valid) drifts_seen++;
      end
      if (out_tvalid && out_tready) begin
        got.u = out_user_t'(out_tuser);
        got.d = out_data_t'(out_tdata);
        results_seen++;
        if (expected_q.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("Result %0d arrived with no event waiting for it", results_seen);
        end else begin
          want = expected_q.pop_front();
          compare_field("forward", 64'(want.u.forward), 64'(got.u.forward));
          compare_field("new_stream", 64'(want.u.new_stream), 64'(got.u.new_stream));
          compare_field("drift_valid", 64'(want.u.drift_valid), 64'(got.u.drift_valid));
          compare_field("puller_start", 64'(want.u.puller_start),
                        64'(got.u.puller_start));
          compare_field("puller_stop", 64'(want.u.puller_stop), 64'(got.u.puller_stop));
          compare_field("rate_notify", 64'(want.u.rate_notify), 64'(got.u.rate_notify));
          compare_field("new_sample_start", want.d.new_sample_start,
                        got.d.new_sample_start);
          compare_field("drift", 64'($unsigned(want.d.drift)),
                        64'($unsigned(got.d.drift)));
          compare_field("drift_network_ts", 64'(want.d.drift_network_ts),
                        64'(got.d.drift_network_ts));
          compare_field("notify_rate", 64'(want.d.notify_rate), 64'(got.d.notify_rate));
        end
      end
      outstanding = expected_q.size();
    end
  end

endmodule

>>> dv/testbench.sv
// Top of the lock detector testbench: clock, reset, stimulus and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import tld_pkg::*;

  // Generous bound on the length of the run.
  localparam int CYCLE_LIMIT = 1_000_000;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   cfg_wr_en   = 1'b0;
  logic [CNT_W-1:0]       cfg_wr_data = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  // Fields from bit 0 up: network_ts, rx_ts, duration_jiffies, sample_start,
  // max_deviation, jiffies_per_sample, sample_rate.
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  // Fields from bit 0 up: op (2 bits), has_puller, has_timestamp.
  logic [IN_TUSER_W-1:0]  in_tuser    = '0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // Fields from bit 0 up: new_sample_start, drift, drift_network_ts, notify_rate.
  logic [OUT_TDATA_W-1:0] out_tdata;
  // Fields from bit 0 up: forward, new_stream, drift_valid, puller_start,
  // puller_stop, rate_notify.
  logic [OUT_TUSER_W-1:0] out_tuser;

  int failures;
  int outstanding;
  int results_seen;
  int new_streams_seen;
  int drifts_seen;
  int cycles = 0;

  // Percent of cycles in which each side holds back; changed between sections.
  int tx_idle_pct = 29;
  int rx_idle_pct = 77;

  // Timestamp relation of the current random session: the base receive-minus-network
  // offset, and the deviation limit of its last stream start, which bounds the jitter.
  logic [TS_W-1:0] cur_base = '0;
  logic [TS_W-1:0] cur_dev  = '0;

  always #2 clk = ~clk;

  timestamp_lock_detector_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  tld_event_checker event_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .failures         (failures),
    .outstanding      (outstanding),
    .results_seen     (results_seen),
    .new_streams_seen (new_streams_seen),
    .drifts_seen      (drifts_seen)
  );

  // The receiver decides afresh every cycle whether it takes a result.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
      $display("Verification failed");
      $finish;
    end
  end

  // Every field carries random content so that unused fields toggle too; the
  // helpers below overwrite the fields that matter for a given event.
  function automatic in_data_t random_payload();
    in_data_t d;
    d.network_ts             = $urandom;
    d.rx_ts                  = $urandom;
    d.duration_jiffies       = $urandom_range(1) ? $urandom : $urandom_range(100000);
    d.sample_start[63:32]    = $urandom;
    d.sample_start[31:0]     = $urandom;
    d.max_deviation          = $urandom;
    d.jiffies_per_sample     = $urandom;
    d.sample_rate            = $urandom;
    return d;
  endfunction

  // Stream start fields, biased toward the corners: zero and full deviation,
  // zero, one and full jiffies per sample, and sample starts close to wrapping.
  function automatic in_data_t shape_stream(input in_data_t d);
    case ($urandom_range(3))
      0: d.max_deviation = '0;
      1: d.max_deviation = '1;
      2: d.max_deviation = $urandom_range(1000);
      default: ;
    endcase
    case ($urandom_range(4))
      0: d.jiffies_per_sample = '0;
      1: d.jiffies_per_sample = 32'd1;
      2: d.jiffies_per_sample = '1;
      3: d.jiffies_per_sample = $urandom_range(5000, 1);
      default: ;
    endcase
    if ($urandom_range(3) == 0) d.sample_start[63:32] = '1;
    cur_dev = d.max_deviation;
    return d;
  endfunction

  // Offers one event and returns at the edge where its transfer happens. The
  // ready line is looked at on the falling edge, where it is settled, so the
  // decision never depends on event order at the rising edge.
  task automatic send_event(input in_user_t u, input in_data_t d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= u;
    in_tdata  <= d;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_mode(input logic puller);
    in_user_t u;
    u.op            = OP_MODE;
    u.has_puller    = puller;
    u.has_timestamp = 1'($urandom_range(1));
    send_event(u, random_payload());
  endtask

  task automatic send_halt();
    in_user_t u;
    u.op            = OP_HALT;
    u.has_puller    = 1'($urandom_range(1));
    u.has_timestamp = 1'($urandom_range(1));
    send_event(u, random_payload());
  endtask

  task automatic send_stream(input logic [SAMP_W-1:0] start, input logic [TS_W-1:0] dev,
                             input logic [TS_W-1:0] jps, input logic [TS_W-1:0] rate);
    in_user_t u;
    in_data_t d;
    u.op                 = OP_STREAM;
    u.has_puller         = 1'($urandom_range(1));
    u.has_timestamp      = 1'($urandom_range(1));
    d                    = random_payload();
    d.sample_start       = start;
    d.max_deviation      = dev;
    d.jiffies_per_sample = jps;
    d.sample_rate        = rate;
    send_event(u, d);
  endtask

  task automatic send_audio(input logic has_ts, input logic [TS_W-1:0] net,
                            input logic [TS_W-1:0] rx, input logic [TS_W-1:0] dur);
    in_user_t u;
    in_data_t d;
    u.op               = OP_AUDIO;
    u.has_puller       = 1'($urandom_range(1));
    u.has_timestamp    = has_ts;
    d                  = random_payload();
    d.network_ts       = net;
    d.rx_ts            = rx;
    d.duration_jiffies = dur;
    send_event(u, d);
  endtask

  // Writes the lock count. Only called with nothing in flight.
  task automatic write_lock_count(input logic [CNT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Drops valid and waits until every predicted result has been transferred,
  // then lets the clock run on so the block is truly quiet.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly well-formed audio: timestamped blocks whose delta stays within half
  // the deviation limit of the base, so long runs reach lock. Now and then
  // (disrupt_pm per thousand) a disturbing event is mixed in instead.
  task automatic send_random_events(input int count, input int disrupt_pm);
    in_user_t        u;
    in_data_t        d;
    logic [TS_W-1:0] jitter;
    for (int k = 0; k < count; k++) begin
      d               = random_payload();
      u.op            = OP_AUDIO;
      u.has_puller    = 1'($urandom_range(1));
      u.has_timestamp = 1'b1;
      if ($urandom_range(999) < disrupt_pm) begin
        case ($urandom_range(4))
          0: begin
            u.op            = OP_MODE;
            u.has_puller    = ($urandom_range(3) != 0);
            u.has_timestamp = 1'($urandom_range(1));
            cur_base        = $urandom;
          end
          1: begin
            u.op            = OP_HALT;
            u.has_timestamp = 1'($urandom_range(1));
            cur_base        = $urandom;
          end
          2: begin
            u.op            = OP_STREAM;
            u.has_timestamp = 1'($urandom_range(1));
            d               = shape_stream(d);
          end
          // Audio without timestamps.
          3: u.has_timestamp = 1'b0;
          // Audio with an unrelated delta: breaks a lock attempt, or gives a
          // drift anywhere in the signed range once locked.
          default: ;
        endcase
      end else begin
        jitter = $urandom_range(cur_dev >> 1);
        if ($urandom_range(1)) jitter = 32'd0 - jitter;
        d.rx_ts = d.network_ts + cur_base + jitter;
      end
      send_event(u, d);
    end
  endtask

  // One random section: set the lock count while idle, open a timestamped session
  // with a puller and a stream start, then run the random mix.
  task automatic run_section(input logic [CNT_W-1:0] lock_count, input int count,
                             input int disrupt_pm);
    in_user_t u;
    wait_idle();
    write_lock_count(lock_count);
    cur_base        = $urandom;
    u.op            = OP_MODE;
    u.has_puller    = 1'b1;
    u.has_timestamp = 1'($urandom_range(1));
    send_event(u, random_payload());
    u.op = OP_STREAM;
    send_event(u, shape_stream(random_payload()));
    send_random_events(count, disrupt_pm);
  endtask

  initial begin
    logic [TS_W-1:0] net;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, first at the reset lock count of 8.
    // Audio before any mode change simply passes through.
    send_audio(1'b1, 32'h0000_1000, 32'h0000_2000, 32'd100);
    // Stream start near the top of the sample range, so the lock start wraps.
    send_stream(64'hFFFF_FFFF_FFFF_FFF0, 32'd5, 32'd3, 32'd48000);
    send_mode(1'b1);
    // First audio decides on timestamps; its delta crosses the 32-bit wrap.
    send_audio(1'b1, 32'hFFFF_FFF0, 32'h0000_0010, 32'hFFFF_FFFF);
    // Seven consistent blocks lock; an untimestamped block in between only adds
    // its duration to the discarded total.
    for (int k = 0; k < 7; k++) begin
      if (k == 3) send_audio(1'b0, $urandom, $urandom, 32'hFFFF_FFFF);
      net = 32'h8000_0000 + k;
      send_audio(1'b1, net, net + 32'h1F + (k % 3), 32'hFFFF_FFFF);
    end
    // Locked: drift reports, the second one at the most negative drift.
    send_audio(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'd0);
    send_audio(1'b1, 32'h1234_5678, 32'h9234_5698, 32'd0);
    // Stream start while timestamped gives a rate notice; zero deviation and a
    // zero divisor are held for the next lock.
    send_stream(64'h0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_halt();

    // The fastest lock count; a deviation of one exceeds the zero limit.
    wait_idle();
    write_lock_count(8'd2);
    send_audio(1'b1, 32'd100, 32'd150, 32'd7);
    send_audio(1'b1, 32'd100, 32'd151, 32'd7);
    send_audio(1'b1, 32'd200, 32'd251, 32'd7);
    send_audio(1'b1, 32'd300, 32'd351, 32'd7);
    // Relock with no stream start held: no replacement stream.
    send_halt();
    send_audio(1'b1, 32'd5, 32'd4, 32'd1);
    send_audio(1'b1, 32'd6, 32'd5, 32'd1);
    // Leaving timestamp mode stops the puller; the next stream is plain.
    send_mode(1'b0);
    send_audio(1'b1, $urandom, $urandom, $urandom);
    send_mode(1'b1);
    send_audio(1'b0, $urandom, $urandom, $urandom);

    // Random sections: sender idles less than the receiver first.
    run_section(8'd3, 150, 60);
    run_section(8'd255, 280, 3);
    // Then the other way round.
    tx_idle_pct = 77;
    rx_idle_pct = 29;
    run_section(8'd1, 280, 3);
    run_section(8'd0, 60, 60);
    // Then back to back on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_section(8'd5, 130, 40);
    run_section(8'd7, 40, 80);

    // Drain, then watch a while longer for any stray result.
    wait_idle();
    repeat (80) @(posedge clk);

    $display("Checked %0d results, including %0d replacement stream starts and %0d drift reports.",
             results_seen, new_streams_seen, drifts_seen);
    $display("Lock counts covered: reset value 8, then 2, 3, 255, 1, 0, 5 and 7.");
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
